@@ rtl/plti_pkg.sv @@
// ----------------------------------------------------------------------------
// plti_pkg
// shared widths, codes and sequencer states of the table interpolator
// ----------------------------------------------------------------------------
package plti_pkg;

  localparam int unsigned MaxEntries = 256;
  localparam int unsigned IdxW       = $clog2(MaxEntries);
  localparam int unsigned CntW       = IdxW + 1;
  localparam int unsigned XW         = 17;
  localparam int unsigned YW         = 24;
  localparam int unsigned CfgW       = 9;
  localparam int unsigned InDataW    = 72;
  localparam int unsigned OutDataW   = 32;

  // serial divider: dividend is 2*|p| + den, divisor is 2*den
  localparam int unsigned DivW       = 44;
  localparam int unsigned DvsW       = 18;
  localparam int unsigned DivCntW    = $clog2(DivW + 1);

  localparam logic [XW-1:0] OneQ16   = 17'h10000;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatClamp   = 2'd1;
  localparam logic [1:0] StatNoFound = 2'd2;
  localparam logic [1:0] StatNeg     = 2'd3;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FETCH = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_DST   = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_FIN   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

endpackage

@@ rtl/piecewise_linear_table_interp.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp
// piecewise-linear interpolation over a loadable table of (x, y) points
// ----------------------------------------------------------------------------
// Load words (tuser = 0) write one table point and give no result; the input
// stays ready for the next word. A query word (tuser = 1) with x in Q1.16
// returns the first y for x = 0, the last valid y with status clamped for
// x >= 1.0, and otherwise the y interpolated between the first point from
// slot 1 on whose x lies above the query and the point before it, rounded
// half away from zero and saturated to signed Q8.16 (the left y itself where
// the pair's x does not rise), status negative for a negative value; no such
// point gives value 0, status not-found. The table is one 256 x 41 bit
// memory with one write and one read port, read once per cycle, so the scan
// steps through the points in turn. A query with a slope term then passes
// the multiply, the divider setup, the serial divider (44 quotient bits, one
// per cycle, then a done flag) and the rounding step; end queries skip the
// scan. The input is not ready while a query is in flight; a finished
// result sits in the output register so the next word can be taken while it
// waits. Table entries hold garbage until loaded; entries_in_use must only
// cover loaded points.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp
  import plti_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration: entries_in_use
  input  logic                cfg_we_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  // input words
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [7:0] entry_index, [24:8] entry_x, [48:25] entry_y, [65:49] query_x,
  // [71:66] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [0] cmd
  input  logic                s_axis_tuser,
  // result words
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [23:0] value, [25:24] status, [31:26] zero
  output logic [OutDataW-1:0] m_axis_tdata
);

  // input word fields
  logic [IdxW-1:0] in_idx;
  logic [XW-1:0]   in_ex;
  logic [YW-1:0]   in_ey;
  logic [XW-1:0]   in_qx;

  assign in_idx = s_axis_tdata[7:0];
  assign in_ex  = s_axis_tdata[24:8];
  assign in_ey  = s_axis_tdata[48:25];
  assign in_qx  = s_axis_tdata[65:49];

  // entries_in_use register and its clamped last index
  logic [CfgW-1:0] n_cfg_q;
  logic [IdxW-1:0] last_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_cfg_q <= CfgW'(MaxEntries);
    end else if (cfg_we_i) begin
      n_cfg_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (n_cfg_q < CfgW'(2)) begin
      last_idx = IdxW'(1);
    end else if (n_cfg_q > CfgW'(MaxEntries)) begin
      last_idx = IdxW'(MaxEntries - 1);
    end else begin
      last_idx = IdxW'(n_cfg_q - 1'b1);
    end
  end

  // sequencer state
  state_e              state_q, state_d;
  logic [CntW-1:0]     ptr_q, ptr_d;
  logic                out_vld_q, out_vld_d;

  // datapath registers
  logic [XW-1:0]       q_q, q_d;
  logic                clamp_q, clamp_d;
  logic [XW-1:0]       px_q, px_d;
  logic [YW-1:0]       py_q, py_d;
  logic signed [XW:0]  num_q, num_d;
  logic signed [XW:0]  den_q, den_d;
  logic signed [YW:0]  dy_q, dy_d;
  logic [YW-1:0]       y0_q, y0_d;
  logic                slope_q, slope_d;
  logic                neg_q, neg_d;
  logic signed [42:0]  prod_q, prod_d;
  logic [YW-1:0]       res_val_q, res_val_d;
  logic [1:0]          res_st_q, res_st_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  // table memory, x in the upper bits and y in the lower bits
  logic [XW+YW-1:0]    mem [MaxEntries];
  logic [XW+YW-1:0]    rd_q;
  logic [IdxW-1:0]     rd_addr;
  logic                in_acc;
  logic [XW-1:0]       rd_x;
  logic [YW-1:0]       rd_y;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign rd_x   = rd_q[XW+YW-1:YW];
  assign rd_y   = rd_q[YW-1:0];

  always_comb begin
    if (state_q == S_IDLE) begin
      rd_addr = (in_qx >= OneQ16) ? last_idx : '0;
    end else begin
      rd_addr = ptr_q[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tuser == CmdLoad) begin
      mem[in_idx] <= {in_ex, in_ey};
    end
    rd_q <= mem[rd_addr];
  end

  // serial divider and the rounding/saturation tail
  logic               div_start;
  logic               div_done;
  logic [DivW-1:0]    div_quot;
  logic [42:0]        mag;
  logic [DivW-1:0]    dividend;
  logic [DvsW-1:0]    divisor;
  logic [DivW-1:0]    r_eff;
  logic signed [DivW:0] sum;

  assign mag       = prod_q[42] ? 43'(-prod_q) : 43'(prod_q);
  assign dividend  = {1'b0, mag[41:0], 1'b0} + DivW'(den_q[XW-1:0]);
  assign divisor   = {den_q[XW-1:0], 1'b0};
  assign div_start = (state_q == S_DST);
  assign r_eff     = slope_q ? div_quot : '0;
  assign sum       = neg_q ? ($signed({{(DivW+1-YW){y0_q[YW-1]}}, y0_q})
                              - $signed({1'b0, r_eff}))
                           : ($signed({{(DivW+1-YW){y0_q[YW-1]}}, y0_q})
                              + $signed({1'b0, r_eff}));

  plti_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    out_vld_d  = out_vld_q;
    q_d        = q_q;
    clamp_d    = clamp_q;
    px_d       = px_q;
    py_d       = py_q;
    num_d      = num_q;
    den_d      = den_q;
    dy_d       = dy_q;
    y0_d       = y0_q;
    slope_d    = slope_q;
    neg_d      = neg_q;
    prod_d     = prod_q;
    res_val_d  = res_val_q;
    res_st_d   = res_st_q;
    out_data_d = out_data_q;

    // result register drains independently of the sequencer
    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc && s_axis_tuser == CmdQuery) begin
          q_d     = in_qx;
          clamp_d = (in_qx >= OneQ16);
          ptr_d   = CntW'(1);
          if (in_qx == '0 || in_qx >= OneQ16) begin
            state_d = S_FETCH;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_FETCH: begin
        // end-point query, the read of the end entry is back
        res_val_d = rd_y;
        res_st_d  = clamp_q ? StatClamp : StatOk;
        state_d   = S_OUT;
      end
      S_SCAN: begin
        // rd_q holds entry ptr_q - 1 while ptr_q is being read
        if (ptr_q == CntW'(1)) begin
          px_d  = rd_x;
          py_d  = rd_y;
          ptr_d = ptr_q + 1'b1;
        end else if (rd_x > q_q) begin
          num_d   = $signed({1'b0, q_q}) - $signed({1'b0, px_q});
          den_d   = $signed({1'b0, rd_x}) - $signed({1'b0, px_q});
          dy_d    = $signed({rd_y[YW-1], rd_y}) - $signed({py_q[YW-1], py_q});
          y0_d    = py_q;
          slope_d = ($signed({1'b0, rd_x}) - $signed({1'b0, px_q})) > 0;
          neg_d   = 1'b0;
          state_d = slope_d ? S_MUL : S_FIN;
        end else if ((ptr_q - 1'b1) == CntW'(last_idx)) begin
          res_val_d = '0;
          res_st_d  = StatNoFound;
          state_d   = S_OUT;
        end else begin
          px_d  = rd_x;
          py_d  = rd_y;
          ptr_d = ptr_q + 1'b1;
        end
      end
      S_MUL: begin
        prod_d  = 43'(dy_q * num_q);
        state_d = S_DST;
      end
      S_DST: begin
        neg_d   = prod_q[42];
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (sum > $signed((DivW+1)'(8388607))) begin
          res_val_d = 24'h7F_FFFF;
        end else if (sum < -$signed((DivW+1)'(8388608))) begin
          res_val_d = 24'h80_0000;
        end else begin
          res_val_d = sum[YW-1:0];
        end
        res_st_d = res_val_d[YW-1] ? StatNeg : StatOk;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_data_d = {6'd0, res_st_q, res_val_q};
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ptr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q        <= q_d;
    clamp_q    <= clamp_d;
    px_q       <= px_d;
    py_q       <= py_d;
    num_q      <= num_d;
    den_q      <= den_d;
    dy_q       <= dy_d;
    y0_q       <= y0_d;
    slope_q    <= slope_d;
    neg_q      <= neg_d;
    prod_q     <= prod_d;
    res_val_q  <= res_val_d;
    res_st_q   <= res_st_d;
    out_data_q <= out_data_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ rtl/plti_div.sv @@
// ----------------------------------------------------------------------------
// plti_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module plti_div
  import plti_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] quot_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DvsW-1:0]    rem_q, rem_d;
  logic [DvsW-1:0]    dvs_q, dvs_d;
  logic [DivW-1:0]    quo_q, quo_d;
  logic [DvsW:0]      rem_sh;
  logic [DvsW:0]      diff;
  logic               ge;

  // shift in the next dividend bit, subtract if it fits
  assign rem_sh = {rem_q, quo_q[DivW-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DivW);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DvsW-1:0] : rem_sh[DvsW-1:0];
      quo_d = {quo_q[DivW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

@@ verif/plti_result_checker.sv @@
// ----------------------------------------------------------------------------
// plti_result_checker
// watches the table interpolator ports, predicts every query result in order
// and compares it field by field with what the block returns
// ----------------------------------------------------------------------------
module plti_result_checker
  import plti_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  output int unsigned         fail_cnt_o,
  output int unsigned         pending_o,
  output int unsigned         results_o,
  output logic [3:0][31:0]    status_seen_o
);

  localparam longint SatHi = 64'sd8388607;
  localparam longint SatLo = -64'sd8388608;

  typedef struct packed {
    logic [5:0]      pad;
    logic [XW-1:0]   query_x;
    logic [YW-1:0]   entry_y;
    logic [XW-1:0]   entry_x;
    logic [IdxW-1:0] entry_index;
  } in_word_t;

  typedef struct packed {
    logic [5:0]    pad;
    logic [1:0]    status;
    logic [YW-1:0] value;
  } out_word_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [YW-1:0] value;
  } interp_res_t;

  logic [XW-1:0]        pt_x [MaxEntries];
  logic signed [YW-1:0] pt_y [MaxEntries];
  logic [CfgW-1:0]      pts_cfg;
  interp_res_t          expected_q [$];
  int unsigned          fail_cnt;
  int unsigned          results;
  logic [3:0][31:0]     status_seen;

  function automatic interp_res_t predict_query(input logic [XW-1:0] q);
    interp_res_t res;
    int unsigned n;
    int unsigned m;
    int unsigned i;
    bit found;
    longint num, den, y0, y1, prod, mag, quo, val;
    n = 32'(pts_cfg);
    if (n < 2) n = 2;
    if (n > MaxEntries) n = MaxEntries;
    res.status = StatOk;
    res.value = '0;
    m = 0;
    found = 1'b0;
    if (q == '0) begin
      res.value = pt_y[0];
    end else if (q >= OneQ16) begin
      res.value = pt_y[n-1];
      res.status = StatClamp;
    end else begin
      // first point strictly above the query, scan starts at slot 1
      for (i = 1; i < n && !found; i++) begin
        if (pt_x[i] > q) begin
          m = i - 1;
          found = 1'b1;
        end
      end
      if (!found) begin
        res.status = StatNoFound;
      end else begin
        num = longint'(q) - longint'(pt_x[m]);
        den = longint'(pt_x[m+1]) - longint'(pt_x[m]);
        y0 = longint'(pt_y[m]);
        y1 = longint'(pt_y[m+1]);
        val = y0;
        if (den > 0) begin
          // half away from zero on the magnitude
          prod = (y1 - y0) * num;
          mag = (prod < 0) ? -prod : prod;
          quo = (2 * mag + den) / (2 * den);
          val = (prod < 0) ? y0 - quo : y0 + quo;
        end
        if (val > SatHi) val = SatHi;
        if (val < SatLo) val = SatLo;
        res.value = val[YW-1:0];
        res.status = (val < 0) ? StatNeg : StatOk;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    in_word_t    iw;
    out_word_t   ow;
    interp_res_t exp_res;
    if (!rst_ni) begin
      for (int unsigned k = 0; k < MaxEntries; k++) begin
        pt_x[k] = '0;
        pt_y[k] = '0;
      end
      pts_cfg = CfgW'(MaxEntries);
      expected_q.delete();
      fail_cnt = 0;
      results = 0;
      status_seen = '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        ow = m_axis_tdata;
        results++;
        if (expected_q.size() == 0) begin
          $display("%0t: result with no query waiting, got value %0d status %0d",
                   $time, $signed(ow.value), ow.status);
          fail_cnt++;
        end else begin
          exp_res = expected_q.pop_front();
          if (ow.value !== exp_res.value) begin
            $display("%0t: value mismatch, expected %0d, got %0d",
                     $time, $signed(exp_res.value), $signed(ow.value));
            fail_cnt++;
          end
          if (ow.status !== exp_res.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, exp_res.status, ow.status);
            fail_cnt++;
          end
        end
      end
      if (cfg_we_i) pts_cfg = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        iw = s_axis_tdata;
        if (s_axis_tuser == CmdLoad) begin
          pt_x[iw.entry_index] = iw.entry_x;
          pt_y[iw.entry_index] = iw.entry_y;
        end else begin
          exp_res = predict_query(iw.query_x);
          status_seen[exp_res.status] = status_seen[exp_res.status] + 1;
          expected_q.push_back(exp_res);
        end
      end
    end
    fail_cnt_o    <= fail_cnt;
    pending_o     <= expected_q.size();
    results_o     <= results;
    status_seen_o <= status_seen;
  end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the piecewise-linear table interpolator
// ----------------------------------------------------------------------------
// Fills the whole table first so no query can touch an unloaded slot, runs a
// short directed set at a four-point table (ends, extremes, no bracketing
// point, descending first pair, extrapolation with saturation, half-way
// rounding), then random phases: each one picks a table size (extremes and
// out-of-range register values included), reloads an ascending table and
// sends mostly queries mixed with stray loads that break the ordering. The
// sender idles in bursts and the result side stalls on its own pattern; a
// separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import plti_pkg::*;

  localparam int unsigned CycleLimit   = 4_000_000;
  localparam int unsigned RandomWords  = 1050;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned DrainCycles  = 320;

  // same word layout as s_axis_tdata, lowest field last
  typedef struct packed {
    logic [5:0]      pad;
    logic [XW-1:0]   query_x;
    logic [YW-1:0]   entry_y;
    logic [XW-1:0]   entry_x;
    logic [IdxW-1:0] entry_index;
  } in_word_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgW-1:0]     cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = CmdLoad;
  logic                m_axis_tready = 1'b0;
  logic                s_axis_tready;
  logic                m_axis_tvalid;
  logic [OutDataW-1:0] m_axis_tdata;

  int unsigned      fail_cnt;
  int unsigned      pending;
  int unsigned      results;
  logic [3:0][31:0] status_seen;

  // sender burst state and receiver stall pattern
  int unsigned burst_left   = 0;
  int unsigned max_gap      = 0;
  int unsigned rx_left      = 0;
  int unsigned rx_max_stall = 0;

  int unsigned cycle_cnt    = 0;
  int unsigned words_sent   = 0;
  int unsigned queries_sent = 0;
  int unsigned sizes_used   = 0;

  always #4 clk_i = ~clk_i;

  piecewise_linear_table_interp u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  plti_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending),
    .results_o     (results),
    .status_seen_o (status_seen)
  );

  // result side: ready runs and stall runs of random length,
  // rx_max_stall of zero means never stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_left <= 0;
    end else if (rx_left != 0) begin
      rx_left <= rx_left - 1;
    end else if (!m_axis_tready || rx_max_stall == 0) begin
      m_axis_tready <= 1'b1;
      rx_left <= $urandom_range(0, 30);
    end else begin
      m_axis_tready <= 1'b0;
      rx_left <= $urandom_range(0, rx_max_stall - 1);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_cnt, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one word, held until the block takes it; a new burst starts after a gap when max_gap is not zero
  task automatic send_word(input logic cmd, input in_word_t w);
    if (burst_left == 0) begin
      if (max_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, max_gap)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    if (cmd == CmdQuery) queries_sent++;
  endtask

  task automatic load_point(input int unsigned idx, input logic [XW-1:0] x,
                            input logic [YW-1:0] y);
    in_word_t w;
    w = '0;
    w.entry_index = idx[IdxW-1:0];
    w.entry_x = x;
    w.entry_y = y;
    send_word(CmdLoad, w);
  endtask

  task automatic query_at(input logic [XW-1:0] q);
    in_word_t w;
    w = '0;
    w.query_x = q;
    send_word(CmdQuery, w);
  endtask

  // stop sending, let every expected result come back, then let the block settle
  task automatic wait_idle(input int unsigned settle);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_entries(input logic [CfgW-1:0] v);
    wait_idle(SettleCycles);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sizes_used++;
  endtask

  // strictly ascending points in slots 0..n-1; first x sometimes above zero
  // so low queries extrapolate, last x sometimes short of 1.0 so high
  // queries find no bracket
  task automatic load_ramp(input int unsigned n, input bit narrow_y);
    int unsigned x0;
    int unsigned pitch;
    int unsigned i;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    x0 = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2000) : 0;
    pitch = (32'h10000 - x0) / (n - 1);
    for (i = 0; i < n; i++) begin
      if (i == 0) x = XW'(x0);
      else if (i == n - 1 && $urandom_range(0, 1) == 1) x = OneQ16;
      else x = XW'(x0 + i * pitch - $urandom_range(0, pitch / 2));
      // small slopes exercise the rounding, full range the saturation
      if (narrow_y) y = YW'($urandom_range(0, 4000) - 2000);
      else y = YW'($urandom);
      load_point(i, x, y);
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned cfg_val;
    int unsigned n_eff;
    int unsigned n_words;
    int unsigned start_words;
    int unsigned pick;
    int unsigned j;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // whole table at the reset size, then both ends
    max_gap = 3;
    rx_max_stall <= 6;
    load_ramp(MaxEntries, 1'b0);
    query_at(17'd0);
    query_at(OneQ16);

    // directed set on a four-point table
    write_entries(9'd4);
    load_point(0, 17'd0, 24'h800000);
    load_point(1, 17'd16384, 24'h7FFFFF);
    load_point(2, 17'd32768, 24'h000000);
    load_point(3, OneQ16, 24'd100);
    query_at(17'd0);
    query_at(OneQ16);
    query_at(17'h1FFFF);      // far beyond one, still clamped
    query_at(17'd1);
    query_at(17'd8192);
    query_at(17'd16384);      // exactly on a point
    query_at(17'd65535);
    // last point pulled in below the query: nothing brackets it
    load_point(3, 17'd40000, 24'd100);
    query_at(17'd50000);
    // first pair descending: left y with no slope term
    load_point(0, 17'd20000, 24'd5);
    load_point(1, 17'd10000, 24'hFFFFF9);
    query_at(17'd5000);
    // first point above the query with a steep slope: saturates low
    load_point(0, 17'd8000, 24'd0);
    load_point(1, 17'd9000, 24'h7FFFFF);
    query_at(17'd1);
    // exact half steps, both signs round away from zero
    load_point(0, 17'd0, 24'd0);
    load_point(1, 17'd2, 24'd1);
    query_at(17'd1);
    load_point(1, 17'd2, 24'hFFFFFF);
    query_at(17'd1);

    // random phases, each with its own table size and idle pattern
    start_words = words_sent;
    phase = 0;
    while (words_sent - start_words < RandomWords) begin
      case (phase)
        0: cfg_val = 511;     // above the table depth
        1: cfg_val = 0;       // below the minimum of two
        2: cfg_val = 2;
        3: cfg_val = 256;
        default: begin
          pick = $urandom_range(0, 99);
          if (pick < 8) cfg_val = $urandom_range(0, 1);
          else if (pick < 14) cfg_val = $urandom_range(257, 511);
          else if (pick < 24) cfg_val = $urandom_range(200, 256);
          else if (pick < 40) cfg_val = $urandom_range(17, 64);
          else cfg_val = $urandom_range(2, 16);
        end
      endcase
      write_entries(cfg_val[CfgW-1:0]);
      n_eff = (cfg_val < 2) ? 2 : (cfg_val > MaxEntries) ? MaxEntries : cfg_val;

      // some phases without sender gaps, some without receiver stalls
      max_gap = (phase % 4 == 1) ? 0 : $urandom_range(1, 12);
      rx_max_stall <= (phase % 3 == 2) ? 0 : $urandom_range(1, 40);

      load_ramp(n_eff, $urandom_range(0, 2) == 0);
      n_words = $urandom_range(40, 120);
      for (j = 0; j < n_words; j++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) load_point($urandom_range(0, 255), XW'($urandom), YW'($urandom));
        else if (pick < 10) query_at(17'd0);
        else if (pick < 14) query_at(OneQ16);
        else if (pick < 18) query_at(XW'($urandom_range(32'h10001, 32'h1FFFF)));
        else query_at(XW'($urandom_range(1, 65535)));
      end
      phase++;
    end

    wait_idle(DrainCycles);

    $display("run: %0d words in (%0d queries), %0d results, %0d table sizes, %0d phases",
             words_sent, queries_sent, results, sizes_used, phase);
    $display("result mix: %0d ok, %0d clamped, %0d unbracketed, %0d negative",
             status_seen[StatOk], status_seen[StatClamp],
             status_seen[StatNoFound], status_seen[StatNeg]);
    if (fail_cnt == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
